// ===== src/kafq_pkg.sv =====
// Package for the keyframe-aware frame queue: sizes, codes, descriptor and result types.
// Used by kafq_ctrl and keyframe_aware_frame_queue; kafq_ram is generic and takes none of it.
package kafq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int QDEPTH_W = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;

	// command kinds
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	// answer status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BAD = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_CLOSED = 2'd3;

	// result kinds
	localparam logic RK_RELEASE = 1'b0;
	localparam logic RK_ANSWER = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_EMIT_RD,
		S_EMIT,
		S_POP_RD,
		S_POP,
		S_ANS
	} state_t;

	typedef struct packed {
		logic [63:0] tstamp;
		logic        key;
		logic [31:0] length;
		logic [31:0] handle;
	} entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] handle;
		logic [31:0] length;
		logic        key;
		logic [63:0] tstamp;
	} cmd_t;

	typedef struct packed {
		logic                rkind;
		logic [1:0]          status;
		logic                accepted;
		logic [31:0]         handle;
		logic [31:0]         length;
		logic                keyf;
		logic [63:0]         tstamp;
		logic [QDEPTH_W-1:0] depth;
		logic [31:0]         dropped;
		logic                last;
	} res_t;

	function automatic idx_t nxt_idx(input idx_t i);
		nxt_idx = (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == DROP_MAX) ? v : v + 32'd1;
	endfunction

endpackage

// ===== src/keyframe_aware_frame_queue.sv =====
// Top level of the keyframe-aware frame queue: stream ports, output register, checks.
// Depends on kafq_pkg, kafq_ctrl and kafq_ram.
//
// Usage:
//  A command transaction enters on the s_axis side: push (a frame descriptor), pop or
//  close, selected by tuser. Each command gives zero or more release transactions
//  (descriptors dropped from the head on overflow, in drop order) and then one answer,
//  which carries tlast. Every result reports the depth and saturating drop count as
//  they stand after the whole command.
//  Timing: s_axis_tready is high only while the sequencer is idle. A push, close or empty
//  pop answer is formed, unless the push overflows, in the answer state entered on acceptance
//  and then passes the output register to m_axis; a pop that returns an entry first takes
//  a registered RAM read. A new command can be taken the cycle after the answer is formed.
//  An overflow push walks the ring through the single descriptor RAM read port: it reads
//  and counts each dropped entry, then reads each again to release it, then answers.
//  The result sits in one output register; while m_axis_tready is low the sequencer
//  holds and the next result waits, nothing is lost.
//  Reset empties the queue, clears the closed and dropping marks and the drop count;
//  descriptor storage needs no clearing since only held entries are read.
module keyframe_aware_frame_queue import kafq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // buffer_handle, frame_length, timestamp_us
	input  logic [2:0]   s_axis_tuser,  // kind, is_keyframe
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, accepted, out_handle, out_length, out_keyframe, out_timestamp,
	// queue_depth, dropped_count, zero pad
	output logic [175:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser,  // result_kind
	output logic         m_axis_tlast
);

	cmd_t cmd;
	res_t res, m_res_q;
	logic res_valid, slot_free, m_valid_q;

	assign cmd.kind = s_axis_tuser[1:0];
	assign cmd.key = s_axis_tuser[2];
	assign cmd.handle = s_axis_tdata[31:0];
	assign cmd.length = s_axis_tdata[63:32];
	assign cmd.tstamp = s_axis_tdata[127:64];

	assign slot_free = !m_valid_q || m_axis_tready;

	kafq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(s_axis_tvalid),
		.cmd_ready(s_axis_tready),
		.cmd      (cmd),
		.slot_free(slot_free),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = m_res_q.rkind;
	assign m_axis_tlast = m_res_q.last;
	assign m_axis_tdata = {7'd0, m_res_q.dropped, m_res_q.depth, m_res_q.tstamp,
		m_res_q.keyf, m_res_q.length, m_res_q.handle, m_res_q.accepted, m_res_q.status};

	// results are only formed while no new command can be taken
	a_busy_when_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("result formed while accepting commands");

	// only the answer closes a command's run of results
	a_last_is_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((m_res_q.rkind == RK_ANSWER) == m_res_q.last))
		else $error("tlast does not match result kind");

	a_release_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_res_q.rkind == RK_RELEASE) |->
		(m_res_q.status == STAT_OK && !m_res_q.accepted))
		else $error("release carries answer fields");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_res_q.depth <= QDEPTH_W'(DEPTH)))
		else $error("queue depth beyond capacity");

endmodule

// ===== src/kafq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kafq_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/kafq_ctrl.sv =====
// Sequencer of the frame queue: ring pointers, drop walk and result generation.
// Depends on kafq_pkg and holds the descriptor store as a kafq_ram instance.
module kafq_ctrl import kafq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_ready,
	input  cmd_t   cmd,
	input  logic   slot_free,
	output logic   res_valid,
	output res_t   res
);

	state_t state_q, state_d;

	idx_t        head_q, tail_q, ptr_q;
	cnt_t        fill_q, drops_q;
	logic [31:0] drop_q;
	logic        closed_q, dropping_q;

	// pending answer and latched push payload
	logic [1:0]  ans_status_q;
	logic        ans_acc_q;
	logic        store_q;
	entry_t      wr_entry_q;

	entry_t rd_entry;
	logic   ram_we;
	logic   accept;
	logic   push_bad, push_skip, push_full, scan_more;

	assign accept = cmd_valid && cmd_ready;
	assign push_bad = (cmd.handle == 32'd0) || (cmd.length == 32'd0);
	// transactions that only answer: rejected, after close, or non-key while dropping
	assign push_skip = push_bad || closed_q || (dropping_q && !cmd.key);
	assign push_full = (fill_q == cnt_t'(DEPTH));
	// walk stops at a keyframe head or once every entry is gone
	assign scan_more = (drops_q != cnt_t'(DEPTH)) && !rd_entry.key;

	kafq_ram #(
		.WIDTH($bits(entry_t)),
		.WORDS(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(wr_entry_q),
		.raddr(ptr_q),
		.rdata(rd_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						KIND_PUSH: state_d = (!push_skip && push_full) ? S_SCAN_RD : S_ANS;
						KIND_POP:  state_d = (fill_q != '0) ? S_POP_RD : S_ANS;
						default:   state_d = S_ANS;
					endcase
				end
			end
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN:    state_d = scan_more ? S_SCAN_RD : S_EMIT_RD;
			S_EMIT_RD: state_d = S_EMIT;
			S_EMIT: begin
				if (slot_free) begin
					state_d = (drops_q == cnt_t'(1)) ? S_ANS : S_EMIT_RD;
				end
			end
			S_POP_RD: state_d = S_POP;
			S_POP:    state_d = slot_free ? S_IDLE : S_POP;
			S_ANS:    state_d = slot_free ? S_IDLE : S_ANS;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = (state_q == S_IDLE);
		ram_we = 1'b0;
		res_valid = 1'b0;
		res.rkind = RK_ANSWER;
		res.status = STAT_OK;
		res.accepted = 1'b0;
		res.handle = '0;
		res.length = '0;
		res.keyf = 1'b0;
		res.tstamp = '0;
		res.depth = QDEPTH_W'(fill_q);
		res.dropped = drop_q;
		res.last = 1'b1;
		case (state_q)
			S_EMIT: begin
				res_valid = slot_free;
				res.rkind = RK_RELEASE;
				res.handle = rd_entry.handle;
				res.length = rd_entry.length;
				res.keyf = rd_entry.key;
				res.tstamp = rd_entry.tstamp;
				res.last = 1'b0;
			end
			S_POP: begin
				res_valid = slot_free;
				res.handle = rd_entry.handle;
				res.length = rd_entry.length;
				res.keyf = rd_entry.key;
				res.tstamp = rd_entry.tstamp;
			end
			S_ANS: begin
				res_valid = slot_free;
				res.status = ans_status_q;
				res.accepted = ans_acc_q;
				ram_we = slot_free && store_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			ptr_q <= '0;
			fill_q <= '0;
			drops_q <= '0;
			drop_q <= '0;
			closed_q <= 1'b0;
			dropping_q <= 1'b0;
			ans_status_q <= STAT_OK;
			ans_acc_q <= 1'b0;
			store_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ans_status_q <= STAT_OK;
						ans_acc_q <= 1'b0;
						store_q <= 1'b0;
						case (cmd.kind)
							KIND_PUSH: begin
								if (push_bad) begin
									ans_status_q <= STAT_BAD;
								end else if (closed_q) begin
									ans_status_q <= STAT_OK;
								end else if (dropping_q && !cmd.key) begin
									drop_q <= sat_inc(drop_q);
								end else begin
									ans_acc_q <= 1'b1;
									store_q <= 1'b1;
									if (push_full) begin
										// first drop is certain; walk counts the rest
										dropping_q <= 1'b1;
										drops_q <= cnt_t'(1);
										drop_q <= sat_inc(drop_q);
										ptr_q <= nxt_idx(head_q);
									end else begin
										dropping_q <= 1'b0;
										fill_q <= fill_q + cnt_t'(1);
									end
								end
							end
							KIND_POP: begin
								if (fill_q != '0) begin
									fill_q <= fill_q - cnt_t'(1);
									ptr_q <= head_q;
									head_q <= nxt_idx(head_q);
								end else begin
									ans_status_q <= closed_q ? STAT_CLOSED : STAT_EMPTY;
								end
							end
							KIND_CLOSE: closed_q <= 1'b1;
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						drops_q <= drops_q + cnt_t'(1);
						drop_q <= sat_inc(drop_q);
						ptr_q <= nxt_idx(ptr_q);
					end else begin
						// depth after the whole step, shown on every release
						fill_q <= fill_q - drops_q + cnt_t'(1);
						ptr_q <= head_q;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						drops_q <= drops_q - cnt_t'(1);
						head_q <= nxt_idx(head_q);
						ptr_q <= nxt_idx(ptr_q);
					end
				end
				S_ANS: begin
					if (slot_free && store_q) begin
						tail_q <= nxt_idx(tail_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_entry_q.handle <= cmd.handle;
			wr_entry_q.length <= cmd.length;
			wr_entry_q.key <= cmd.key;
			wr_entry_q.tstamp <= cmd.tstamp;
		end
	end

endmodule
